>>> rtl/bcbp_pkg.sv
// Shared types and constants for the bracket class bitmap parser.
package bcbp_pkg;

  // Byte codes the parser reacts to
  localparam logic [7:0] ChNul      = 8'h00;
  localparam logic [7:0] ChRBracket = 8'h5D;
  localparam logic [7:0] ChDash     = 8'h2D;
  localparam logic [7:0] ChLowN     = 8'h6E;
  localparam logic [7:0] ChLowT     = 8'h74;
  localparam logic [7:0] ChLowD     = 8'h64;
  localparam logic [7:0] ChUpD      = 8'h44;
  localparam logic [7:0] ChLowS     = 8'h73;
  localparam logic [7:0] ChUpS      = 8'h53;
  localparam logic [7:0] ChLowW     = 8'h77;
  localparam logic [7:0] ChUpW      = 8'h57;
  localparam logic [7:0] ChNewline  = 8'h0A;
  localparam logic [7:0] ChTab      = 8'h09;
  localparam logic [7:0] EscReset   = 8'h5C;

  // Class masks: word 0 covers bytes 0-63, word 1 bytes 64-127
  localparam logic [63:0] DigitW0 = 64'h03FF_0000_0000_0000;
  localparam logic [63:0] SpaceW0 = 64'h0000_0001_0000_3E00;
  localparam logic [63:0] WordW1  = 64'h07FF_FFFE_87FF_FFFE;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_START = 3'd1,
    ST_BAD_END   = 3'd2,
    ST_MIXED     = 3'd3,
    ST_ORDER     = 3'd4,
    ST_UNCLOSED  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_SET,
    ACT_RANGE,
    ACT_CLASS
  } act_e;

  typedef enum logic [1:0] {
    CLS_DIGIT,
    CLS_SPACE,
    CLS_WORD
  } cls_e;

  typedef enum logic [1:0] {
    KIND_OTHER,
    KIND_DIGIT,
    KIND_LOWER,
    KIND_UPPER
  } kind_e;

  // One queued command: optional clear, at most one bitmap update, optional result
  typedef struct packed {
    logic       clear;
    act_e       act;
    logic [7:0] lo;
    logic [7:0] hi;
    cls_e       cls;
    logic       inv;
    logic       emit;
    status_e    status;
    logic       neg;
  } op_t;

  function automatic kind_e kind_of(input logic [7:0] b);
    kind_e k;
    k = KIND_OTHER;
    if (b >= 8'h30 && b <= 8'h39) k = KIND_DIGIT;
    else if (b >= 8'h61 && b <= 8'h7A) k = KIND_LOWER;
    else if (b >= 8'h41 && b <= 8'h5A) k = KIND_UPPER;
    return k;
  endfunction

endpackage

>>> rtl/bcbp_front.sv
// Front end: tracks the parse phase and turns bytes into queued commands.
module bcbp_front import bcbp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] class_byte_i,
  input  logic       open_class_i,
  input  logic       negated_open_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output op_t        q_op_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_NORMAL,
    PH_HELD,
    PH_RANGE,
    PH_ESC
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] held_q, held_d;
  logic       neg_q, neg_d;
  logic [7:0] esc_q;
  op_t        op;
  kind_e      kl, kh;
  logic       take;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = ~q_full_i;
  assign take        = in_valid_i & in_ready_o;

  assign kl = kind_of(held_q);
  assign kh = kind_of(class_byte_i);

  // Decode one byte against the current phase
  always_comb begin
    phase_e ph;
    ph      = open_class_i ? PH_NORMAL : phase_q;
    neg_d   = open_class_i ? negated_open_i : neg_q;
    held_d  = open_class_i ? 8'h00 : held_q;
    phase_d = ph;
    op        = '0;
    op.clear  = open_class_i;
    op.act    = ACT_NONE;
    op.cls    = CLS_DIGIT;
    op.status = ST_OK;
    op.neg    = neg_d;
    op.lo     = held_d;
    op.hi     = class_byte_i;
    case (ph)
      PH_NORMAL, PH_HELD: begin
        if (ph == PH_HELD && class_byte_i == ChDash) begin
          phase_d = PH_RANGE;
        end else begin
          if (ph == PH_HELD) op.act = ACT_SET;
          // fresh byte with nothing held
          if (class_byte_i == ChNul) begin
            op.emit = 1'b1; op.status = ST_UNCLOSED; phase_d = PH_IDLE;
          end else if (class_byte_i == ChRBracket) begin
            op.emit = 1'b1; op.status = ST_OK; phase_d = PH_IDLE;
          end else if (class_byte_i == esc_q) begin
            phase_d = PH_ESC;
          end else begin
            held_d  = class_byte_i;
            phase_d = PH_HELD;
          end
        end
      end
      PH_RANGE: begin
        if (kl == KIND_OTHER)       op.status = ST_BAD_START;
        else if (kh == KIND_OTHER)  op.status = ST_BAD_END;
        else if (kl != kh)          op.status = ST_MIXED;
        else if (held_q >= class_byte_i) op.status = ST_ORDER;
        if (op.status != ST_OK) begin
          op.emit = 1'b1;
          phase_d = PH_IDLE;
        end else begin
          op.act  = ACT_RANGE;
          phase_d = PH_NORMAL;
        end
      end
      PH_ESC: begin
        phase_d = PH_NORMAL;
        op.lo   = class_byte_i;
        op.act  = ACT_SET;
        case (class_byte_i)
          ChNul: begin
            op.act = ACT_NONE; op.emit = 1'b1; op.status = ST_UNCLOSED;
            phase_d = PH_IDLE;
          end
          ChLowN:  op.lo = ChNewline;
          ChLowT:  op.lo = ChTab;
          ChLowD:  begin op.act = ACT_CLASS; op.cls = CLS_DIGIT; end
          ChUpD:   begin op.act = ACT_CLASS; op.cls = CLS_DIGIT; op.inv = 1'b1; end
          ChLowS:  begin op.act = ACT_CLASS; op.cls = CLS_SPACE; end
          ChUpS:   begin op.act = ACT_CLASS; op.cls = CLS_SPACE; op.inv = 1'b1; end
          ChLowW:  begin op.act = ACT_CLASS; op.cls = CLS_WORD; end
          ChUpW:   begin op.act = ACT_CLASS; op.cls = CLS_WORD; op.inv = 1'b1; end
          default: op.lo = class_byte_i;
        endcase
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  // Only beats that change the bitmap or emit go to the queue
  assign q_op_o   = op;
  assign q_push_o = take & (op.clear | op.emit | (op.act != ACT_NONE));

  // Phase, held byte, flag and escape register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      held_q  <= 8'h00;
      neg_q   <= 1'b0;
      esc_q   <= EscReset;
    end else begin
      if (cfg_valid_i) esc_q <= cfg_data_i;
      if (take) begin
        phase_q <= phase_d;
        held_q  <= held_d;
        neg_q   <= neg_d;
      end
    end
  end

endmodule

>>> rtl/bcbp_queue.sv
// Small FIFO of commands between front end and bitmap back end.
module bcbp_queue import bcbp_pkg::*; #(
  parameter int Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  push_op_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output op_t  pop_op_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  op_t            slot_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o   = (cnt_q == FullCnt);
  assign empty_o  = (cnt_q == '0);
  assign pop_op_o = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= push_op_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

>>> rtl/bcbp_back.sv
// Back end: applies queued commands to the 256-bit bitmap and holds the result beat.
module bcbp_back import bcbp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         q_empty_i,
  input  op_t          q_op_i,
  output logic         q_pop_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [255:0] out_bits_o,
  output logic         out_neg_o,
  output status_e      out_status_o
);

  logic [3:0][63:0] bits_q, bits_d, mask;
  logic [63:0]      w0, w1, rng;
  logic             out_valid_q;
  logic [255:0]     out_bits_q;
  logic             out_neg_q;
  status_e          out_status_q;

  // Pop unless the command emits and the result slot stays occupied
  assign q_pop_o = ~q_empty_i & (~q_op_i.emit | ~out_valid_q | out_ready_i);

  // Range bits inside one 64-bit word
  assign rng = ({64{1'b1}} << q_op_i.lo[5:0]) & ({64{1'b1}} >> (6'd63 - q_op_i.hi[5:0]));

  // Mask for this command
  always_comb begin
    mask = '0;
    w0   = DigitW0;
    w1   = '0;
    case (q_op_i.cls)
      CLS_SPACE: w0 = SpaceW0;
      CLS_WORD:  w1 = WordW1;
      default:   w0 = DigitW0;
    endcase
    case (q_op_i.act)
      ACT_SET:   mask[q_op_i.lo[7:6]][q_op_i.lo[5:0]] = 1'b1;
      ACT_RANGE: mask[q_op_i.lo[7:6]] = rng;
      ACT_CLASS: begin
        if (q_op_i.inv) mask = {{64{1'b1}}, {64{1'b1}}, ~w1, ~w0};
        else            mask = {64'h0, 64'h0, w1, w0};
      end
      default:   mask = '0;
    endcase
  end

  assign bits_d = (q_op_i.clear ? '0 : bits_q) | mask;

  // Bitmap and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) bits_q <= bits_d;
      if (q_pop_o && q_op_i.emit)  out_valid_q <= 1'b1;
      else if (out_ready_i)        out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_op_i.emit) begin
      out_bits_q   <= (q_op_i.status == ST_OK) ? bits_d : '0;
      out_neg_q    <= q_op_i.neg;
      out_status_q <= q_op_i.status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_bits_o   = out_bits_q;
  assign out_neg_o    = out_neg_q;
  assign out_status_o = out_status_q;

endmodule

>>> rtl/bracket_class_bitmap_parser_core.sv
// Top level of the bracket class bitmap parser.
// A class result is registered in the command queue, then in the output register.
// Throughput: one byte per cycle; the front end decodes in the accept cycle and the back
// end applies one queued command per cycle, set by the single bitmap update path.
// A stalled output stalls input only once the command queue fills.
// Reset (async, active low): idle until an open beat, bitmap clear, escape byte 0x5C.
module bracket_class_bitmap_parser_core import bcbp_pkg::*; #(
  parameter int QueueDepth = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_data_i,     // escape_byte
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i, // [7:0] class_byte
  input  logic [1:0]   s_axis_tuser_i, // [0] open_class, [1] negated_open
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [255:0] m_axis_tdata_o, // class_word0..3, 64 bits each from bit 0
  output logic [3:0]   m_axis_tuser_o  // [0] class_negated, [3:1] parse_status
);

  logic    q_push, q_pop, q_full, q_empty;
  op_t     push_op, pop_op;
  logic    out_neg;
  status_e out_status;

  bcbp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (s_axis_tvalid_i),
    .in_ready_o     (s_axis_tready_o),
    .class_byte_i   (s_axis_tdata_i),
    .open_class_i   (s_axis_tuser_i[0]),
    .negated_open_i (s_axis_tuser_i[1]),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_op_o         (push_op)
  );

  bcbp_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_op_i (push_op),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .empty_o   (q_empty),
    .pop_op_o  (pop_op)
  );

  bcbp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_op_i       (pop_op),
    .q_pop_o      (q_pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_bits_o   (m_axis_tdata_o),
    .out_neg_o    (out_neg),
    .out_status_o (out_status)
  );

  assign m_axis_tuser_o = {out_status, out_neg};

endmodule

>>> rtl/bcbp_checker.sv
// Port-level checks for the parser core, bound to the top level.
module bcbp_checker import bcbp_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [255:0] m_axis_tdata_o,
  input logic [3:0]   m_axis_tuser_o
);

  // A stalled result beat stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result beat dropped while stalled");

  // Status code is always a defined one
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o[3:1] <= ST_UNCLOSED))
    else $error("undefined parse status");

  // Failed classes carry an empty bitmap
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o[3:1] != ST_OK) |-> (m_axis_tdata_o == '0))
    else $error("bitmap not cleared on error beat");

endmodule

bind bracket_class_bitmap_parser_core bcbp_checker u_bcbp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

>>> sim/bcbp_class_checker.sv
`timescale 1ns / 1ps
// Bracket class parser checker: watches all channels, predicts each class result, compares beats.
module bcbp_class_checker import bcbp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [7:0]   cfg_data_i,    // escape_byte
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [7:0]   s_tdata_i,     // [7:0] class_byte
  input  logic [1:0]   s_tuser_i,     // [0] open_class, [1] negated_open
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic [255:0] m_tdata_i,     // class_word0..3, 64 bits each from bit 0
  input  logic [3:0]   m_tuser_i,     // [0] class_negated, [3:1] parse_status
  output int unsigned  fail_count_o,
  output int unsigned  pending_o,
  output int unsigned  ok_classes_o,
  output int unsigned  err_classes_o
);

  // Scan position inside the bracket expression
  typedef enum logic [2:0] {
    WaitOpen,
    Fresh,
    Held,
    RangeEnd,
    Escaped
  } scan_e;

  typedef struct packed {
    logic [255:0] words;
    logic         negated;
    status_e      status;
  } class_result_t;

  class_result_t expected_classes[$];
  class_result_t want_r;

  logic [255:0] member_map;
  logic [7:0]   held_char;
  scan_e        scan;
  logic         neg_flag;
  logic [7:0]   esc_char;

  int unsigned fail_count;
  int unsigned result_beats;
  int unsigned ok_classes;
  int unsigned err_classes;
  int          word_idx;

  // Character kind for range ends
  function automatic kind_e char_kind(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return KIND_DIGIT;  // '0'..'9'
    if (c >= 8'h61 && c <= 8'h7A) return KIND_LOWER;  // 'a'..'z'
    if (c >= 8'h41 && c <= 8'h5A) return KIND_UPPER;  // 'A'..'Z'
    return KIND_OTHER;
  endfunction

  // Checks in fixed order: start, end, kind match, ascending
  function automatic status_e range_status(input logic [7:0] lo, input logic [7:0] hi);
    kind_e k_lo;
    kind_e k_hi;
    k_lo = char_kind(lo);
    k_hi = char_kind(hi);
    if (k_lo == KIND_OTHER) return ST_BAD_START;
    if (k_hi == KIND_OTHER) return ST_BAD_END;
    if (k_lo != k_hi) return ST_MIXED;
    if (lo >= hi) return ST_ORDER;
    return ST_OK;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    fail_count++;
    $display("[%0t] result beat %0d: %s got %h expected %h",
             $time, result_beats, what, got, want);
  endtask

  // Queue a result; error results carry an empty bitmap
  task automatic close_class(input status_e st);
    class_result_t r;
    r.words   = (st == ST_OK) ? member_map : '0;
    r.negated = neg_flag;
    r.status  = st;
    expected_classes.push_back(r);
    scan = WaitOpen;
  endtask

  // A byte seen with nothing held
  task automatic take_fresh(input logic [7:0] c);
    if (c == ChNul) close_class(ST_UNCLOSED);
    else if (c == ChRBracket) close_class(ST_OK);
    else if (c == esc_char) scan = Escaped;
    else begin
      held_char = c;
      scan = Held;
    end
  endtask

  // OR in a predefined class, or its complement
  task automatic merge_class(input logic [63:0] w0, input logic [63:0] w1, input logic inv);
    if (inv) begin
      member_map[63:0]    = member_map[63:0] | ~w0;
      member_map[127:64]  = member_map[127:64] | ~w1;
      member_map[255:128] = '1;
    end else begin
      member_map[63:0]   = member_map[63:0] | w0;
      member_map[127:64] = member_map[127:64] | w1;
    end
  endtask

  // One accepted input beat through the bitmap builder
  task automatic parse_class_byte(input logic [7:0] c, input logic open, input logic neg);
    status_e st;
    int      i;
    if (open) begin
      member_map = '0;
      neg_flag   = neg;
      held_char  = '0;
      scan       = Fresh;
    end
    case (scan)
      Fresh: take_fresh(c);
      Held: begin
        if (c == ChDash) scan = RangeEnd;
        else begin
          member_map[held_char] = 1'b1;
          take_fresh(c);
        end
      end
      RangeEnd: begin
        st = range_status(held_char, c);
        if (st != ST_OK) close_class(st);
        else begin
          for (i = held_char; i <= c; i++) member_map[i] = 1'b1;
          scan = Fresh;
        end
      end
      Escaped: begin
        scan = Fresh;
        case (c)
          ChNul:  close_class(ST_UNCLOSED);
          ChLowN: member_map[ChNewline] = 1'b1;
          ChLowT: member_map[ChTab] = 1'b1;
          ChLowD: merge_class(DigitW0, '0, 1'b0);
          ChUpD:  merge_class(DigitW0, '0, 1'b1);
          ChLowS: merge_class(SpaceW0, '0, 1'b0);
          ChUpS:  merge_class(SpaceW0, '0, 1'b1);
          ChLowW: merge_class(DigitW0, WordW1, 1'b0);
          ChUpW:  merge_class(DigitW0, WordW1, 1'b1);
          default: member_map[c] = 1'b1;
        endcase
      end
      default: scan = WaitOpen;
    endcase
  endtask

  // Monitor: result beats are checked before the input beat of the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      member_map = '0;
      held_char  = '0;
      scan       = WaitOpen;
      neg_flag   = 1'b0;
      esc_char   = EscReset;
      expected_classes.delete();
      fail_count   = 0;
      result_beats = 0;
      ok_classes   = 0;
      err_classes  = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        result_beats++;
        if (expected_classes.size() == 0) begin
          report_mismatch("unexpected beat, tdata low word", m_tdata_i[63:0], '0);
        end else begin
          want_r = expected_classes.pop_front();
          for (word_idx = 0; word_idx < 4; word_idx++)
            if (m_tdata_i[64*word_idx +: 64] !== want_r.words[64*word_idx +: 64])
              report_mismatch($sformatf("class_word%0d", word_idx),
                              m_tdata_i[64*word_idx +: 64], want_r.words[64*word_idx +: 64]);
          if (m_tuser_i[0] !== want_r.negated)
            report_mismatch("class_negated", 64'(m_tuser_i[0]), 64'(want_r.negated));
          if (m_tuser_i[3:1] !== want_r.status)
            report_mismatch("parse_status", 64'(m_tuser_i[3:1]), 64'(want_r.status));
          if (want_r.status == ST_OK) ok_classes++;
          else err_classes++;
        end
      end
      if (cfg_valid_i && cfg_ready_i) esc_char = cfg_data_i;
      if (s_tvalid_i && s_tready_i) parse_class_byte(s_tdata_i, s_tuser_i[0], s_tuser_i[1]);
    end
    fail_count_o  <= fail_count;
    pending_o     <= expected_classes.size();
    ok_classes_o  <= ok_classes;
    err_classes_o <= err_classes;
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// Testbench top: drives byte streams and escape settings into the parser and gives the verdict.
module tb;
  import bcbp_pkg::*;

  localparam int IdlePct       = 11;
  localparam int HoldCycles    = 400;
  localparam int WatchdogLimit = 5000;
  localparam int SettleCycles  = 8;
  localparam int PhaseItems    = 290;
  localparam int PhaseCount    = 7;
  localparam int DirectedCount = 27;

  // Directed beats, first beat in the top bits: {negated_open, open_class, class_byte}
  localparam logic [DirectedCount*10-1:0] DirectedSeq = {
    // [^a-z\W] closes cleanly
    {1'b1, 1'b1, 8'h61}, {1'b0, 1'b0, 8'h2D}, {1'b0, 1'b0, 8'h7A},
    {1'b0, 1'b0, 8'h5C}, {1'b0, 1'b0, 8'h57}, {1'b0, 1'b0, 8'h5D},
    // \n then a held byte then end of string; stray negate flag on the held byte
    {1'b0, 1'b1, 8'h5C}, {1'b0, 1'b0, 8'h6E}, {1'b1, 1'b0, 8'h78}, {1'b0, 1'b0, 8'h00},
    // 9-0 descending
    {1'b0, 1'b1, 8'h39}, {1'b0, 1'b0, 8'h2D}, {1'b0, 1'b0, 8'h30},
    // a-Z mixed kinds, negated
    {1'b1, 1'b1, 8'h61}, {1'b0, 1'b0, 8'h2D}, {1'b0, 1'b0, 8'h5A},
    // 5-] bad range end taken raw
    {1'b0, 1'b1, 8'h35}, {1'b0, 1'b0, 8'h2D}, {1'b0, 1'b0, 8'h5D},
    // 0xFF-3 bad range start
    {1'b0, 1'b1, 8'hFF}, {1'b0, 1'b0, 8'h2D}, {1'b0, 1'b0, 8'h33},
    // dropped after an error
    {1'b1, 1'b0, 8'h71},
    // empty class
    {1'b0, 1'b1, 8'h5D},
    // class abandoned by a new open, then escape followed by end of string
    {1'b0, 1'b1, 8'h6B}, {1'b1, 1'b1, 8'h5C}, {1'b0, 1'b0, 8'h00}
  };

  logic         clk_i    = 1'b0;
  logic         rst_ni   = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_data  = EscReset;
  logic         s_tvalid  = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata   = '0;
  logic [1:0]   s_tuser   = '0;
  logic         m_tvalid;
  logic         m_tready  = 1'b0;
  logic [255:0] m_tdata;
  logic [3:0]   m_tuser;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned ok_classes;
  int unsigned err_classes;

  logic [7:0]  esc_now = EscReset;
  logic        open_next = 1'b0;
  logic        neg_next  = 1'b0;
  bit          hold_req  = 1'b0;
  bit          steady    = 1'b0;
  int unsigned items_sent = 0;
  int unsigned cfg_writes = 0;
  int unsigned quiet_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bracket_class_bitmap_parser_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  bcbp_class_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .s_tvalid_i    (s_tvalid),
    .s_tready_i    (s_tready),
    .s_tdata_i     (s_tdata),
    .s_tuser_i     (s_tuser),
    .m_tvalid_i    (m_tvalid),
    .m_tready_i    (m_tready),
    .m_tdata_i     (m_tdata),
    .m_tuser_i     (m_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .ok_classes_o  (ok_classes),
    .err_classes_o (err_classes)
  );

  // Watchdog: cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no beat accepted for %0d cycles, %0d results pending",
               quiet_cycles, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result sink: random back-pressure plus one long hold on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      m_tready <= steady || ($urandom_range(99, 0) >= IdlePct);
    end
  end

  // One input beat with random gaps ahead of it
  task automatic send_beat(input logic [7:0] c, input logic open, input logic neg);
    while (!steady && $urandom_range(99, 0) < IdlePct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tuser  <= {neg, open};
    do @(posedge clk_i); while (!s_tready);
    items_sent++;
  endtask

  // Byte of a class; the first one carries the open flag, the rest a stray negate bit
  task automatic send_char(input logic [7:0] c);
    send_beat(c, open_next, open_next ? neg_next : 1'($urandom_range(1, 0)));
    open_next = 1'b0;
  endtask

  task automatic send_range();
    int k;
    int base;
    int span;
    int lo;
    int hi;
    int tmp;
    k    = $urandom_range(2, 0);
    base = (k == 0) ? 8'h30 : (k == 1) ? 8'h61 : 8'h41;
    span = (k == 0) ? 10 : 26;
    lo   = base + $urandom_range(span - 2, 0);
    hi   = $urandom_range(base + span - 1, lo + 1);
    // Mostly legal ranges, some broken ones
    case ($urandom_range(15, 0))
      0: hi = $urandom_range(255, 0);
      1: lo = $urandom_range(255, 0);
      2: begin
        tmp = lo;
        lo  = hi;
        hi  = tmp;
      end
      3: hi = lo;
      default: ;
    endcase
    send_char(8'(lo));
    send_char(ChDash);
    send_char(8'(hi));
  endtask

  task automatic send_escape();
    logic [7:0] c;
    case ($urandom_range(8, 0))
      0: c = ChLowN;
      1: c = ChLowT;
      2: c = ChLowD;
      3: c = ChUpD;
      4: c = ChLowS;
      5: c = ChUpS;
      6: c = ChLowW;
      7: c = ChUpW;
      default: c = 8'($urandom_range(255, 0));
    endcase
    send_char(esc_now);
    send_char(c);
  endtask

  task automatic send_token();
    int pick;
    pick = $urandom_range(9, 0);
    if (pick < 4) send_char(8'($urandom_range(255, 1)));
    else if (pick < 7) send_range();
    else if (pick < 9) send_escape();
    else send_char(8'($urandom_range(255, 0)));
  endtask

  // One bracket expression: open, tokens, then a close or one of the failing ends
  task automatic send_class();
    int ntok;
    open_next = 1'b1;
    neg_next  = 1'($urandom_range(1, 0));
    ntok = ($urandom_range(9, 0) == 0) ? $urandom_range(14, 7) : $urandom_range(5, 0);
    repeat (ntok) send_token();
    case ($urandom_range(15, 0))
      11: send_char(ChNul);
      12: begin
        send_char(esc_now);
        send_char(ChNul);
      end
      13: ;  // left open, the next open abandons it
      14: begin
        send_char(ChRBracket);
        repeat ($urandom_range(3, 1)) send_char(8'($urandom_range(255, 0)));
      end
      15: begin
        send_char(8'($urandom_range(255, 1)));
        send_char(ChNul);
      end
      default: send_char(ChRBracket);
    endcase
  endtask

  // Unstructured beats with an occasional open
  task automatic send_noise(input int n);
    repeat (n)
      send_beat(8'($urandom_range(255, 0)), $urandom_range(15, 0) == 0,
                1'($urandom_range(1, 0)));
  endtask

  // Stop offering and wait until every class result is back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_escape(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    esc_now = v;
    cfg_writes++;
  endtask

  // Stimulus
  initial begin
    int          i;
    int          ph;
    int unsigned start;
    logic [9:0]  d;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < DirectedCount; i++) begin
      d = DirectedSeq[(DirectedCount - 1 - i)*10 +: 10];
      send_beat(d[7:0], d[8], d[9]);
    end

    // Escape settings: reset value, extremes, '-', ']', random, back to reset value
    for (ph = 0; ph < PhaseCount; ph++) begin
      if (ph > 0) begin
        drain();
        case (ph)
          1: write_escape(8'h00);
          2: write_escape(8'hFF);
          3: write_escape(ChDash);
          4: write_escape(ChRBracket);
          5: write_escape(8'($urandom_range(255, 0)));
          default: write_escape(EscReset);
        endcase
      end
      steady = (ph == 2);
      if (ph == 1) hold_req = 1'b1;
      start = items_sent;
      while (items_sent - start < PhaseItems) begin
        if ($urandom_range(9, 0) < 8) send_class();
        else send_noise($urandom_range(6, 1));
      end
    end
    steady = 1'b0;
    drain();

    $display("Sent %0d class bytes under %0d escape byte settings (0x00 and 0xFF among them),",
             items_sent, cfg_writes + 1);
    $display("with one %0d-cycle output hold; %0d classes closed cleanly, %0d ended in errors.",
             HoldCycles, ok_classes, err_classes);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
